FILE: src/kmp_pkg.sv
// kmp_pkg: shared sizes, codes and controller/datapath interface types
// for the KMP stream matcher. No dependencies.
package kmp_pkg;

    localparam int PATTERN_MAX   = 1024;
    localparam int ADDR_BITS     = $clog2(PATTERN_MAX);
    localparam int LEN_BITS      = ADDR_BITS + 1;
    localparam int POSITION_BITS = 24;
    localparam int SUM_BITS      = (POSITION_BITS + 1 > LEN_BITS) ? POSITION_BITS + 1 : LEN_BITS;

    typedef enum logic [1:0] {
        OP_PATTERN = 2'd0,
        OP_TEXT    = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_MATCH  = 2'd0,
        KIND_BORDER = 2'd1,
        KIND_RANGE  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PAT_START,
        S_PAT_LOAD,
        S_WALK_RD,
        S_WALK_EV,
        S_WALK_END,
        S_MATCH,
        S_RD_WAIT
    } state_t;

    // border store read address source
    typedef enum logic [1:0] {
        RD_LEN = 2'd0,
        RD_IDX = 2'd1,
        RD_J   = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    capture;
        logic    clear;
        logic    pos_inc;
        logic    j_from_ms;
        logic    j_from_border;
        logic    j_step;
        logic    append;
        logic    append_zero;
        logic    ms_from_j;
        logic    ms_from_border;
        rd_sel_t rd_sel;
        logic    emit_match;
        logic    emit_border;
        logic    emit_range;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic first;
        logic len_zero;
        logic len_full;
        logic idx_ok;
        logic j_zero;
        logic j_ge_len;
        logic j_eq_len;
        logic sym_eq;
    } status_t;

endpackage

FILE: src/kmp_ctrl.sv
// kmp_ctrl: sequencing FSM for the KMP stream matcher.
// Depends on kmp_pkg; drives commands into kmp_dp and reads its status.
module kmp_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  kmp_pkg::status_t status,
    output kmp_pkg::cmd_t    cmd,
    output logic             busy
);

    kmp_pkg::state_t state_reg;
    kmp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kmp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = kmp_pkg::RD_J;
        state_next = state_reg;
        busy       = 1'b1;
        unique case (state_reg)
            kmp_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = kmp_pkg::S_DECODE;
                end
            end
            kmp_pkg::S_DECODE:
            begin
                unique case (status.op)
                    kmp_pkg::OP_PATTERN:
                    begin
                        cmd.clear  = status.first;
                        state_next = kmp_pkg::S_PAT_START;
                    end
                    kmp_pkg::OP_TEXT:
                    begin
                        cmd.pos_inc = 1'b1;
                        if (status.len_zero)
                        begin
                            state_next = kmp_pkg::S_IDLE;
                        end
                        else
                        begin
                            cmd.j_from_ms = 1'b1;
                            state_next    = kmp_pkg::S_WALK_RD;
                        end
                    end
                    kmp_pkg::OP_READ:
                    begin
                        if (status.idx_ok)
                        begin
                            cmd.rd_sel = kmp_pkg::RD_IDX;
                            state_next = kmp_pkg::S_RD_WAIT;
                        end
                        else
                        begin
                            cmd.emit_range = 1'b1;
                            state_next     = kmp_pkg::S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = kmp_pkg::S_IDLE;
                    end
                endcase
            end
            kmp_pkg::S_PAT_START:
            begin
                if (status.len_full)
                begin
                    state_next = kmp_pkg::S_IDLE;
                end
                else if (status.len_zero)
                begin
                    cmd.append      = 1'b1;
                    cmd.append_zero = 1'b1;
                    state_next      = kmp_pkg::S_IDLE;
                end
                else
                begin
                    cmd.rd_sel = kmp_pkg::RD_LEN;
                    state_next = kmp_pkg::S_PAT_LOAD;
                end
            end
            kmp_pkg::S_PAT_LOAD:
            begin
                cmd.j_from_border = 1'b1;
                state_next        = kmp_pkg::S_WALK_RD;
            end
            kmp_pkg::S_WALK_RD:
            begin
                // pattern[j] and border[j-1] are fetched together
                cmd.rd_sel = kmp_pkg::RD_J;
                state_next = kmp_pkg::S_WALK_EV;
            end
            kmp_pkg::S_WALK_EV:
            begin
                if (!status.j_zero && (status.j_ge_len || !status.sym_eq))
                begin
                    cmd.j_from_border = 1'b1;
                    state_next        = kmp_pkg::S_WALK_RD;
                end
                else
                begin
                    cmd.j_step = 1'b1;
                    state_next = kmp_pkg::S_WALK_END;
                end
            end
            kmp_pkg::S_WALK_END:
            begin
                if (status.op == kmp_pkg::OP_PATTERN)
                begin
                    cmd.append = 1'b1;
                    state_next = kmp_pkg::S_IDLE;
                end
                else
                begin
                    cmd.ms_from_j = 1'b1;
                    if (status.j_eq_len)
                    begin
                        cmd.rd_sel = kmp_pkg::RD_LEN;
                        state_next = kmp_pkg::S_MATCH;
                    end
                    else
                    begin
                        state_next = kmp_pkg::S_IDLE;
                    end
                end
            end
            kmp_pkg::S_MATCH:
            begin
                cmd.emit_match     = 1'b1;
                cmd.ms_from_border = 1'b1;
                state_next         = kmp_pkg::S_IDLE;
            end
            kmp_pkg::S_RD_WAIT:
            begin
                cmd.emit_border = 1'b1;
                state_next      = kmp_pkg::S_IDLE;
            end
            default:
            begin
                state_next = kmp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/kmp_dp.sv
// kmp_dp: datapath of the KMP stream matcher: pattern and border memories,
// length / match state / text position registers and the result register.
// Depends on kmp_pkg; commanded by kmp_ctrl.
module kmp_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  kmp_pkg::cmd_t                       cmd,
    input  logic [1:0]                          op,
    input  logic [7:0]                          symbol,
    input  logic                                first,
    input  logic [kmp_pkg::LEN_BITS-1:0]        index,
    output kmp_pkg::status_t                    status,
    output logic                                done,
    output logic [1:0]                          kind,
    output logic [kmp_pkg::POSITION_BITS-1:0]   match_start,
    output logic [kmp_pkg::LEN_BITS-1:0]        border
);

    logic [7:0]                        pat_mem [kmp_pkg::PATTERN_MAX];
    logic [kmp_pkg::LEN_BITS-1:0]      bord_mem [kmp_pkg::PATTERN_MAX];

    kmp_pkg::op_t                      op_reg;
    logic [7:0]                        sym_reg;
    logic                              first_reg;
    logic [kmp_pkg::LEN_BITS-1:0]      idx_reg;
    logic [kmp_pkg::LEN_BITS-1:0]      len_reg;
    logic [kmp_pkg::LEN_BITS-1:0]      ms_reg;
    logic [kmp_pkg::LEN_BITS-1:0]      j_reg;
    logic [kmp_pkg::POSITION_BITS-1:0] pos_reg;
    logic [7:0]                        pat_q_reg;
    logic [kmp_pkg::LEN_BITS-1:0]      bord_q_reg;

    logic                              done_reg;
    logic [1:0]                        kind_reg;
    logic [kmp_pkg::POSITION_BITS-1:0] start_reg;
    logic [kmp_pkg::LEN_BITS-1:0]      border_reg;

    logic [kmp_pkg::LEN_BITS-1:0]      len_m1;
    logic [kmp_pkg::LEN_BITS-1:0]      idx_m1;
    logic [kmp_pkg::LEN_BITS-1:0]      j_m1;
    logic [kmp_pkg::ADDR_BITS-1:0]     bord_addr;
    logic [kmp_pkg::SUM_BITS-1:0]      pos_p1;
    logic [kmp_pkg::SUM_BITS-1:0]      len_ext;
    logic [kmp_pkg::SUM_BITS-1:0]      start_diff;
    logic [kmp_pkg::POSITION_BITS-1:0] start_val;

    assign len_m1 = len_reg - kmp_pkg::LEN_BITS'(1);
    assign idx_m1 = idx_reg - kmp_pkg::LEN_BITS'(1);
    assign j_m1   = j_reg - kmp_pkg::LEN_BITS'(1);

    always_comb
    begin
        unique case (cmd.rd_sel)
            kmp_pkg::RD_LEN: bord_addr = len_m1[kmp_pkg::ADDR_BITS-1:0];
            kmp_pkg::RD_IDX: bord_addr = idx_m1[kmp_pkg::ADDR_BITS-1:0];
            kmp_pkg::RD_J:   bord_addr = j_m1[kmp_pkg::ADDR_BITS-1:0];
            default:         bord_addr = '0;
        endcase
    end

    // memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            pat_mem[len_reg[kmp_pkg::ADDR_BITS-1:0]]  <= sym_reg;
            bord_mem[len_reg[kmp_pkg::ADDR_BITS-1:0]] <= cmd.append_zero ? '0 : j_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_q_reg  <= pat_mem[j_reg[kmp_pkg::ADDR_BITS-1:0]];
        bord_q_reg <= bord_mem[bord_addr];
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= kmp_pkg::op_t'(op);
            sym_reg   <= symbol;
            first_reg <= first;
            idx_reg   <= index;
        end
    end

    // walker index
    always_ff @(posedge clk)
    begin
        if (cmd.j_from_ms)
        begin
            j_reg <= ms_reg;
        end
        else if (cmd.j_from_border)
        begin
            j_reg <= bord_q_reg;
        end
        else if (cmd.j_step && status.sym_eq && !status.j_ge_len)
        begin
            j_reg <= j_reg + kmp_pkg::LEN_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ms_reg  <= '0;
            pos_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                len_reg <= '0;
            end
            else if (cmd.append)
            begin
                len_reg <= len_reg + kmp_pkg::LEN_BITS'(1);
            end

            if (cmd.clear)
            begin
                ms_reg <= '0;
            end
            else if (cmd.ms_from_border)
            begin
                ms_reg <= bord_q_reg;
            end
            else if (cmd.ms_from_j)
            begin
                ms_reg <= j_reg;
            end

            if (cmd.clear)
            begin
                pos_reg <= '0;
            end
            else if (cmd.pos_inc && (pos_reg != '1))
            begin
                pos_reg <= pos_reg + kmp_pkg::POSITION_BITS'(1);
            end
        end
    end

    // start = pos + 1 - len, clamped at zero
    assign pos_p1     = kmp_pkg::SUM_BITS'(pos_reg) + kmp_pkg::SUM_BITS'(1);
    assign len_ext    = kmp_pkg::SUM_BITS'(len_reg);
    assign start_diff = pos_p1 - len_ext;
    assign start_val  = (pos_p1 >= len_ext) ? start_diff[kmp_pkg::POSITION_BITS-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit_match | cmd.emit_border | cmd.emit_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_match)
        begin
            kind_reg   <= kmp_pkg::KIND_MATCH;
            start_reg  <= start_val;
            border_reg <= '0;
        end
        else if (cmd.emit_border)
        begin
            kind_reg   <= kmp_pkg::KIND_BORDER;
            start_reg  <= '0;
            border_reg <= bord_q_reg;
        end
        else if (cmd.emit_range)
        begin
            kind_reg   <= kmp_pkg::KIND_RANGE;
            start_reg  <= '0;
            border_reg <= '0;
        end
    end

    always_comb
    begin
        status.op       = op_reg;
        status.first    = first_reg;
        status.len_zero = (len_reg == '0);
        status.len_full = (len_reg == kmp_pkg::LEN_BITS'(kmp_pkg::PATTERN_MAX));
        status.idx_ok   = (idx_reg != '0) && (idx_reg <= len_reg);
        status.j_zero   = (j_reg == '0);
        status.j_ge_len = (j_reg >= len_reg);
        status.j_eq_len = (j_reg == len_reg);
        status.sym_eq   = (pat_q_reg == sym_reg);
    end

    assign done        = done_reg;
    assign kind        = kind_reg;
    assign match_start = start_reg;
    assign border      = border_reg;

endmodule

FILE: src/kmp_stream_matcher.sv
// kmp_stream_matcher: top level of the KMP byte-stream matcher.
// Depends on kmp_pkg, kmp_ctrl and kmp_dp.
//
//  channel   handshake               payload
//  --------  ----------------------  ----------------------------------
//  request   start && !busy          op, symbol, first, index
//  result    done (one-cycle strobe) kind, match_start, border
//
// An accepted request is decoded, then: op 3, an out-of-range read or a text byte with
// no pattern loaded return to idle; a border read and a pattern byte into an empty or
// full pattern go via S_RD_WAIT or S_PAT_START; other bytes walk the failure links,
// and a text byte that ends a match goes via S_MATCH. A result strobes as busy drops.
// Reset is asynchronous and leaves the memories uncleared. Results cannot be stalled:
// done pulses for one cycle.
module kmp_stream_matcher
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          op,
    input  logic [7:0]                          symbol,
    input  logic                                first,
    input  logic [kmp_pkg::LEN_BITS-1:0]        index,
    output logic                                done,
    output logic [1:0]                          kind,
    output logic [kmp_pkg::POSITION_BITS-1:0]   match_start,
    output logic [kmp_pkg::LEN_BITS-1:0]        border
);

    kmp_pkg::cmd_t    cmd;
    kmp_pkg::status_t status;

    kmp_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    kmp_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .op          (op),
        .symbol      (symbol),
        .first       (first),
        .index       (index),
        .status      (status),
        .done        (done),
        .kind        (kind),
        .match_start (match_start),
        .border      (border)
    );

    // a result is only produced by work in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in progress");

    // an accepted request always occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // non-match results carry a zero start position
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (kind != kmp_pkg::KIND_MATCH)) |-> (match_start == '0))
        else $error("nonzero match_start on non-match result");

    // only border replies carry a border value
    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (kind != kmp_pkg::KIND_BORDER)) |-> (border == '0))
        else $error("nonzero border on non-border result");

endmodule

FILE: dv/tb_kmp_stream_matcher.sv
`timescale 1ns / 1ps
// tb_kmp_stream_matcher: self-checking bench for the KMP stream matcher.
// A directed table, a full-length pattern run and random pattern/text sequences
// are checked against an in-bench KMP predictor. Depends on kmp_pkg and the DUT.
module tb_kmp_stream_matcher;

    localparam int WATCHDOG_LIMIT  = 12000;
    localparam int DRAIN_CYCLES    = 2200;
    localparam int PHASE_ITEMS     = 80;
    localparam int FULL_TEXT_BYTES = 64;
    localparam longint unsigned POS_MAX = (64'd1 << kmp_pkg::POSITION_BITS) - 1;

    typedef struct packed {
        kmp_pkg::kind_t                    kind;
        logic [kmp_pkg::POSITION_BITS-1:0] match_start;
        logic [kmp_pkg::LEN_BITS-1:0]      border;
    } reply_t;

    typedef struct packed {
        kmp_pkg::op_t                 op;
        logic [7:0]                   symbol;
        logic                         first;
        logic [kmp_pkg::LEN_BITS-1:0] index;
        logic                         fixed;
        logic                         has_reply;
        reply_t                       reply;
    } step_row_t;

    localparam reply_t NO_REPLY = '{kmp_pkg::KIND_MATCH, 24'd0, 11'd0};

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic [1:0]                        req_op;
    logic [7:0]                        req_symbol;
    logic                              req_first;
    logic [kmp_pkg::LEN_BITS-1:0]      req_index;
    logic                              done;
    logic [1:0]                        kind;
    logic [kmp_pkg::POSITION_BITS-1:0] match_start;
    logic [kmp_pkg::LEN_BITS-1:0]      border;

    // predictor state
    logic [7:0]                   pat_bytes   [kmp_pkg::PATTERN_MAX];
    logic [kmp_pkg::LEN_BITS-1:0] pat_borders [kmp_pkg::PATTERN_MAX];
    int unsigned                  pat_len;
    int unsigned                  match_len;
    longint unsigned              text_pos;

    reply_t pending_replies [$];
    int     err_count = 0;
    int     items_sent;
    int     idle_pct;
    int     stall_cycles = 0;

    // 'a' = 8'h61, 'b' = 8'h62, 'c' = 8'h63
    step_row_t dir_rows [26] = '{
    '{kmp_pkg::OP_READ, 8'h00, 1'b0, 11'd0, 1'b1, 1'b1, '{kmp_pkg::KIND_RANGE, 24'd0, 11'd0}},
    '{kmp_pkg::OP_READ, 8'h00, 1'b0, 11'd1, 1'b1, 1'b1, '{kmp_pkg::KIND_RANGE, 24'd0, 11'd0}},
    '{kmp_pkg::OP_TEXT, 8'h41, 1'b0, 11'd0, 1'b1, 1'b0, NO_REPLY},
    '{kmp_pkg::OP_NONE, 8'h61, 1'b1, 11'd1, 1'b1, 1'b0, NO_REPLY},
    '{kmp_pkg::OP_PATTERN, 8'h61, 1'b1, 11'd0, 1'b1, 1'b0, NO_REPLY},
    '{kmp_pkg::OP_PATTERN, 8'h62, 1'b0, 11'd0, 1'b1, 1'b0, NO_REPLY},
    '{kmp_pkg::OP_PATTERN, 8'h61, 1'b0, 11'd0, 1'b1, 1'b0, NO_REPLY},
    '{kmp_pkg::OP_READ, 8'h00, 1'b0, 11'd3, 1'b1, 1'b1, '{kmp_pkg::KIND_BORDER, 24'd0, 11'd1}},
    '{kmp_pkg::OP_READ, 8'h00, 1'b0, 11'd1, 1'b1, 1'b1, '{kmp_pkg::KIND_BORDER, 24'd0, 11'd0}},
    '{kmp_pkg::OP_READ, 8'h00, 1'b0, 11'd4, 1'b1, 1'b1, '{kmp_pkg::KIND_RANGE, 24'd0, 11'd0}},
    '{kmp_pkg::OP_TEXT, 8'h61, 1'b0, 11'd0, 1'b0, 1'b0, NO_REPLY},
    '{kmp_pkg::OP_TEXT, 8'h62, 1'b0, 11'd0, 1'b0, 1'b0, NO_REPLY},
    '{kmp_pkg::OP_TEXT, 8'h61, 1'b0, 11'd0, 1'b1, 1'b1, '{kmp_pkg::KIND_MATCH, 24'd1, 11'd0}},
    '{kmp_pkg::OP_TEXT, 8'h62, 1'b0, 11'd0, 1'b0, 1'b0, NO_REPLY},
    '{kmp_pkg::OP_TEXT, 8'h61, 1'b0, 11'd0, 1'b1, 1'b1, '{kmp_pkg::KIND_MATCH, 24'd3, 11'd0}},
    '{kmp_pkg::OP_TEXT, 8'h63, 1'b0, 11'd0, 1'b0, 1'b0, NO_REPLY},
    // extend the pattern after text: match state and position are kept
    '{kmp_pkg::OP_PATTERN, 8'h63, 1'b0, 11'd0, 1'b0, 1'b0, NO_REPLY},
    '{kmp_pkg::OP_TEXT, 8'h61, 1'b0, 11'd0, 1'b0, 1'b0, NO_REPLY},
    '{kmp_pkg::OP_READ, 8'h00, 1'b0, 11'd4, 1'b0, 1'b0, NO_REPLY},
    '{kmp_pkg::OP_PATTERN, 8'hFF, 1'b1, 11'd0, 1'b1, 1'b0, NO_REPLY},
    '{kmp_pkg::OP_PATTERN, 8'h00, 1'b0, 11'd0, 1'b1, 1'b0, NO_REPLY},
    '{kmp_pkg::OP_TEXT, 8'h00, 1'b0, 11'd0, 1'b0, 1'b0, NO_REPLY},
    '{kmp_pkg::OP_TEXT, 8'hFF, 1'b0, 11'd0, 1'b0, 1'b0, NO_REPLY},
    '{kmp_pkg::OP_TEXT, 8'h00, 1'b0, 11'd0, 1'b1, 1'b1, '{kmp_pkg::KIND_MATCH, 24'd2, 11'd0}},
    '{kmp_pkg::OP_READ, 8'h00, 1'b0, 11'h7FF, 1'b1, 1'b1, '{kmp_pkg::KIND_RANGE, 24'd0, 11'd0}},
    '{kmp_pkg::OP_READ, 8'h00, 1'b0, 11'd2, 1'b1, 1'b1, '{kmp_pkg::KIND_BORDER, 24'd0, 11'd0}}
    };

    kmp_stream_matcher u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (req_op),
        .symbol      (req_symbol),
        .first       (req_first),
        .index       (req_index),
        .done        (done),
        .kind        (kind),
        .match_start (match_start),
        .border      (border)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // follow failure links from state j until c extends it, then step
    function automatic int unsigned kmp_advance(int unsigned j, int unsigned len,
                                                logic [7:0] c);
        int unsigned k;
        k = j;
        while (k > 0 && (k >= len || pat_bytes[k] != c))
            k = pat_borders[k-1];
        if (k < len && pat_bytes[k] == c)
            k++;
        return k;
    endfunction

    function automatic bit kmp_step(kmp_pkg::op_t o, logic [7:0] c, logic f,
                                    logic [kmp_pkg::LEN_BITS-1:0] ix, output reply_t r);
        int unsigned     b;
        longint unsigned st;
        r = NO_REPLY;
        case (o)
            kmp_pkg::OP_PATTERN:
            begin
                if (f)
                begin
                    pat_len   = 0;
                    match_len = 0;
                    text_pos  = 0;
                end
                if (pat_len < kmp_pkg::PATTERN_MAX)
                begin
                    b = (pat_len > 0) ? kmp_advance(pat_borders[pat_len-1], pat_len, c) : 0;
                    pat_bytes[pat_len]   = c;
                    pat_borders[pat_len] = kmp_pkg::LEN_BITS'(b);
                    pat_len++;
                end
                return 1'b0;
            end
            kmp_pkg::OP_TEXT:
            begin
                if (text_pos < POS_MAX)
                    text_pos++;
                if (pat_len == 0)
                    return 1'b0;
                match_len = kmp_advance(match_len, pat_len, c);
                if (match_len == pat_len)
                begin
                    st = (text_pos + 1 >= pat_len) ? text_pos + 1 - pat_len : 0;
                    match_len = pat_borders[pat_len-1];
                    r.match_start = kmp_pkg::POSITION_BITS'(st);
                    return 1'b1;
                end
                return 1'b0;
            end
            kmp_pkg::OP_READ:
            begin
                if (ix >= 1 && ix <= pat_len)
                begin
                    r.kind   = kmp_pkg::KIND_BORDER;
                    r.border = pat_borders[ix-1];
                end
                else
                    r.kind = kmp_pkg::KIND_RANGE;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // entered and left just after a falling edge
    task automatic issue(kmp_pkg::op_t o, logic [7:0] c, logic f,
                         logic [kmp_pkg::LEN_BITS-1:0] ix,
                         bit fixed = 1'b0, bit fixed_has = 1'b0,
                         reply_t fixed_reply = NO_REPLY);
        reply_t r;
        bit     has;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        req_op     = o;
        req_symbol = c;
        req_first  = f;
        req_index  = ix;
        start      = 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        has = kmp_step(o, c, f, ix, r);
        if (fixed)
        begin
            has = fixed_has;
            r   = fixed_reply;
        end
        if (has)
            pending_replies.push_back(r);
        if (o != kmp_pkg::OP_NONE)
            items_sent++;
        @(negedge clk);
    endtask

    function automatic logic [kmp_pkg::LEN_BITS-1:0] rand_index();
        return kmp_pkg::LEN_BITS'($urandom_range(0, 2047));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // fill the pattern to capacity, then stream its first bytes as text
    task automatic run_full_pattern();
        logic [7:0] pat [kmp_pkg::PATTERN_MAX];
        logic [7:0] a0;
        a0 = rand_byte();
        foreach (pat[i])
            pat[i] = ($urandom_range(0, 7) == 0) ? (a0 ^ 8'h01) : a0;
        foreach (pat[i])
            issue(kmp_pkg::OP_PATTERN, pat[i], i == 0, rand_index());
        issue(kmp_pkg::OP_PATTERN, ~a0, 1'b0, rand_index());    // full: dropped
        issue(kmp_pkg::OP_READ, rand_byte(), 1'b0, 11'd1024);
        issue(kmp_pkg::OP_READ, rand_byte(), 1'b0, 11'd1025);
        issue(kmp_pkg::OP_READ, rand_byte(), 1'b1, 11'd1);
        issue(kmp_pkg::OP_READ, rand_byte(), 1'b0,
              kmp_pkg::LEN_BITS'($urandom_range(1, 1024)));
        for (int i = 0; i < FULL_TEXT_BYTES; i++)
            issue(kmp_pkg::OP_TEXT, pat[i], rand_bit(), rand_index());
        // byte matching nothing: failure walk from the current match state
        issue(kmp_pkg::OP_TEXT, ~a0, 1'b0, rand_index());
        issue(kmp_pkg::OP_TEXT, a0, 1'b0, rand_index());
    endtask

    task automatic run_random(int n_items);
        logic [7:0] alpha [3];
        logic [7:0] pat [$];
        logic [7:0] c;
        int         len;
        int         nsym;
        int         pick;
        int         target;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            foreach (alpha[i])
                alpha[i] = rand_byte();
            nsym = $urandom_range(2, 3);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
            pat.delete();
            for (int i = 0; i < len; i++)
            begin
                pat.push_back(alpha[$urandom_range(0, nsym - 1)]);
                issue(kmp_pkg::OP_PATTERN, pat[i], i == 0, rand_index());
            end
            repeat ($urandom_range(8, 40))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    issue(kmp_pkg::OP_TEXT, alpha[$urandom_range(0, nsym - 1)], rand_bit(),
                          rand_index());
                else if (pick < 62)
                begin
                    foreach (pat[i])
                        issue(kmp_pkg::OP_TEXT, pat[i], rand_bit(), rand_index());
                end
                else if (pick < 77)
                    issue(kmp_pkg::OP_READ, rand_byte(), rand_bit(),
                          kmp_pkg::LEN_BITS'($urandom_range(0, pat.size() + 1)));
                else if (pick < 82)
                    issue(kmp_pkg::OP_READ, rand_byte(), rand_bit(), rand_index());
                else if (pick < 88)
                    issue(kmp_pkg::OP_TEXT, rand_byte(), rand_bit(), rand_index());
                else if (pick < 93)
                begin
                    c = alpha[$urandom_range(0, nsym - 1)];
                    pat.push_back(c);
                    issue(kmp_pkg::OP_PATTERN, c, 1'b0, rand_index());
                end
                else if (pick < 97)
                    issue(kmp_pkg::OP_NONE, rand_byte(), rand_bit(), rand_index());
                else
                begin
                    // broken sequence: restart with a one-byte pattern
                    c = rand_byte();
                    pat.delete();
                    pat.push_back(c);
                    issue(kmp_pkg::OP_PATTERN, c, 1'b1, rand_index());
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("unexpected result: kind %0d, match_start %0d, border %0d",
                       kind, match_start, border);
                err_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    err_count++;
                end
                if (match_start !== want.match_start)
                begin
                    $error("match_start: expected %0d, got %0d", want.match_start, match_start);
                    err_count++;
                end
                if (border !== want.border)
                begin
                    $error("border: expected %0d, got %0d", want.border, border);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        req_op       = kmp_pkg::OP_NONE;
        req_symbol   = 8'h00;
        req_first    = 1'b0;
        req_index    = '0;
        items_sent   = 0;
        idle_pct     = 9;
        pat_len      = 0;
        match_len    = 0;
        text_pos     = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            issue(dir_rows[i].op, dir_rows[i].symbol, dir_rows[i].first, dir_rows[i].index,
                  dir_rows[i].fixed, dir_rows[i].has_reply, dir_rows[i].reply);
        run_full_pattern();
        run_random(PHASE_ITEMS);
        idle_pct = 55;
        run_random(PHASE_ITEMS);
        idle_pct = 0;
        run_random(PHASE_ITEMS);
        start = 1'b0;

        while (pending_replies.size() != 0)
            @(posedge clk);
        // a trailing pattern byte may still be walking its failure links
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
